### rtl/slt_pkg.sv
// Shared constants for the shard lease table: command and status codes, defaults.
package slt_pkg;

    localparam int LEASE_SLOTS_DEF   = 256;
    localparam int NODE_ID_BYTES_DEF = 8;

    // slot field is 8 bits wide, so no more than this many entries are addressable
    localparam int SLOT_SPACE = 256;

    localparam logic [63:0] TTL_RESET = 64'd30000;

    localparam logic [1:0] CMD_CLAIM   = 2'd0;
    localparam logic [1:0] CMD_REQUIRE = 2'd1;
    localparam logic [1:0] CMD_RENEW   = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_BUSY    = 3'd2;
    localparam logic [2:0] ST_PROTO   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

### rtl/shard_lease_table_core.sv
// Shard lease table: slot memory with fencing epochs and read-modify-write command engine.
// The slot entry is registered when the input item is accepted; the result is registered
// from it in the execute state once the output is not stalled. A new item is stalled until
// the last result is loaded, as the slot entry is read and then written back in the slot memory.
// Reset: the lease duration register returns to 30000; per-slot valid flops clear at once,
// so every slot reads as unowned with epoch zero right after reset, no clearing pass needed.
module shard_lease_table_core
    import slt_pkg::*;
#(
    parameter int LEASE_SLOTS   = LEASE_SLOTS_DEF,
    parameter int NODE_ID_BYTES = NODE_ID_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [63:0]               cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic [7:0]                slot,
    input  logic [63:0]               now_ms,
    input  logic [31:0]               shard,
    input  logic [63:0]               presented_epoch,
    input  logic [63:0]               node_id,
    input  logic [3:0]                node_id_len,
    input  logic [63:0]               boot_id_high,
    input  logic [63:0]               boot_id_low,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [63:0]               granted_epoch,
    output logic [63:0]               lease_expiry
);

    localparam int DEPTH  = (LEASE_SLOTS < SLOT_SPACE) ? LEASE_SLOTS : SLOT_SPACE;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NODE_W = 8 * NODE_ID_BYTES;

    localparam logic [16:0] SLOT_LIMIT   = 17'(LEASE_SLOTS);
    localparam logic [3:0]  NODE_LEN_MAX = 4'(NODE_ID_BYTES);

    typedef struct packed {
        logic              owned;
        logic [63:0]       expiry;
        logic [63:0]       epoch;
        logic [31:0]       shard;
        logic [NODE_W-1:0] node;
        logic [3:0]        node_len;
        logic [63:0]       boot_hi;
        logic [63:0]       boot_lo;
    } entry_t;

    // slot memory and per-entry valid flops
    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rdata_reg;
    logic               rvalid_reg;

    state_t             state_reg, state_next;
    logic [63:0]        ttl_reg;

    // latched item
    logic [1:0]         cmd_reg;
    logic [7:0]         slot_reg;
    logic [63:0]        now_reg;
    logic [31:0]        shard_reg;
    logic [63:0]        pepoch_reg;
    logic [63:0]        node_reg;
    logic [3:0]         len_reg;
    logic [63:0]        boot_hi_reg;
    logic [63:0]        boot_lo_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg;
    logic [63:0]        granted_reg;
    logic [63:0]        until_reg;

    logic               in_accept;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx, wr_idx;
    logic               out_load;

    entry_t             entry_cur;
    entry_t             entry_wr;
    logic               mem_we;
    logic [2:0]         status_next;
    logic [63:0]        granted_next;
    logic [63:0]        until_next;

    logic               slot_ok;
    logic               len_ok;
    logic               boot_ok;
    logic               live;
    logic               ttl_zero;
    logic [64:0]        until_sum;
    logic               until_ovf;
    logic [NODE_W-1:0]  node_masked;
    logic               token_diff;
    logic [2:0]         chk_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign rd_en     = in_accept && ({9'd0, slot} < SLOT_LIMIT);
    assign rd_idx    = slot[IDX_W-1:0];
    assign wr_idx    = slot_reg[IDX_W-1:0];
    assign out_load  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_epoch = granted_reg;
    assign lease_expiry  = until_reg;

    // memory read and write-back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx];
        end
        if (mem_we)
        begin
            mem[wr_idx] <= entry_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            ttl_reg       <= TTL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_idx];
            end
            if (mem_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                ttl_reg <= cfg_data;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= cmd;
            slot_reg    <= slot;
            now_reg     <= now_ms;
            shard_reg   <= shard;
            pepoch_reg  <= presented_epoch;
            node_reg    <= node_id;
            len_reg     <= node_id_len;
            boot_hi_reg <= boot_id_high;
            boot_lo_reg <= boot_id_low;
        end
        if (out_load)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            until_reg   <= until_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // bytes at or beyond the id length are ignored
    always_comb
    begin
        for (int i = 0; i < NODE_ID_BYTES; i++)
        begin
            node_masked[8*i +: 8] = (4'(i) < len_reg) ? node_reg[8*i +: 8] : 8'd0;
        end
    end

    assign entry_cur = rvalid_reg ? rdata_reg : '0;
    assign slot_ok   = ({9'd0, slot_reg} < SLOT_LIMIT);
    assign len_ok    = (len_reg != 4'd0) && (len_reg <= NODE_LEN_MAX);
    assign boot_ok   = (boot_hi_reg != 64'd0) || (boot_lo_reg != 64'd0);
    assign live      = entry_cur.owned && (now_reg < entry_cur.expiry);
    assign ttl_zero  = (ttl_reg == 64'd0);
    assign until_sum = {1'b0, now_reg} + {1'b0, ttl_reg};
    assign until_ovf = until_sum[64];

    assign token_diff = (entry_cur.shard != shard_reg) || (entry_cur.epoch != pepoch_reg)
                     || (entry_cur.node_len != len_reg) || (entry_cur.node != node_masked)
                     || (entry_cur.boot_hi != boot_hi_reg) || (entry_cur.boot_lo != boot_lo_reg);

    // live lease, valid token fields and exact token match
    always_comb
    begin
        if (!live)
        begin
            chk_status = ST_BUSY;
        end
        else if ((pepoch_reg == 64'd0) || !len_ok || !boot_ok)
        begin
            chk_status = ST_INVALID;
        end
        else if (token_diff)
        begin
            chk_status = ST_BUSY;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    always_comb
    begin
        status_next  = ST_OK;
        granted_next = 64'd0;
        until_next   = 64'd0;
        mem_we       = 1'b0;
        entry_wr     = entry_cur;

        if (!slot_ok)
        begin
            status_next = ST_INVALID;
        end
        else
        begin
            case (cmd_reg)
                CMD_CLAIM:
                begin
                    if (ttl_zero)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (live)
                    begin
                        status_next = ST_BUSY;
                    end
                    else if (entry_cur.owned && (entry_cur.shard != shard_reg))
                    begin
                        status_next = ST_PROTO;
                    end
                    else if ((entry_cur.epoch == '1) || until_ovf)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!len_ok || !boot_ok)
                    begin
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        granted_next      = entry_cur.epoch + 64'd1;
                        until_next        = until_sum[63:0];
                        entry_wr.owned    = 1'b1;
                        entry_wr.expiry   = until_sum[63:0];
                        entry_wr.epoch    = entry_cur.epoch + 64'd1;
                        entry_wr.shard    = shard_reg;
                        entry_wr.node     = node_masked;
                        entry_wr.node_len = len_reg;
                        entry_wr.boot_hi  = boot_hi_reg;
                        entry_wr.boot_lo  = boot_lo_reg;
                        mem_we            = out_load;
                    end
                end
                CMD_REQUIRE:
                begin
                    status_next = chk_status;
                end
                CMD_RENEW:
                begin
                    if (ttl_zero)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (chk_status != ST_OK)
                    begin
                        status_next = chk_status;
                    end
                    else if (until_ovf)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        until_next      = until_sum[63:0];
                        entry_wr.expiry = until_sum[63:0];
                        mem_we          = out_load;
                    end
                end
                CMD_RELEASE:
                begin
                    status_next = chk_status;
                    if (chk_status == ST_OK)
                    begin
                        // epoch and owner identity stay, so the next claim fences
                        entry_wr.owned  = 1'b0;
                        entry_wr.expiry = 64'd0;
                        mem_we          = out_load;
                    end
                end
                default:
                begin
                    status_next = ST_INVALID;
                end
            endcase
        end
    end

    a_we_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (slot_ok && (status_next == ST_OK) && (state_reg == S_EXEC)))
        else $error("slot write without a successful command");

    a_grant_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (granted_reg != 64'd0)) |-> (status_reg == ST_OK))
        else $error("epoch granted with a refusal status");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without a command in execution");

    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> !rd_en)
        else $error("slot read issued while an item is in execution");

endmodule
